>>> hw/rtl/mrp_pkg.sv
// Shared constants and the witness base table for the Miller-Rabin prime test core.
package mrp_pkg;

  localparam int CAND_W        = 32;  // width of the candidate field on in_tdata
  localparam int OUT_TDATA_W   = 8;   // is_prime padded to a byte
  localparam int BASE_W        = 6;   // largest witness base is 41
  localparam int WITNESS_IDX_W = 4;
  localparam logic [WITNESS_IDX_W-1:0] LAST_WITNESS = 4'd12;

  function automatic logic [BASE_W-1:0] witness_base(input logic [WITNESS_IDX_W-1:0] idx);
    logic [BASE_W-1:0] b;
    case (idx)
      4'd0:    b = 6'd2;
      4'd1:    b = 6'd3;
      4'd2:    b = 6'd5;
      4'd3:    b = 6'd7;
      4'd4:    b = 6'd11;
      4'd5:    b = 6'd13;
      4'd6:    b = 6'd17;
      4'd7:    b = 6'd19;
      4'd8:    b = 6'd23;
      4'd9:    b = 6'd29;
      4'd10:   b = 6'd31;
      4'd11:   b = 6'd37;
      default: b = 6'd41;
    endcase
    return b;
  endfunction

endpackage

>>> hw/rtl/mrp_modmul.sv
// Bit-serial interleaved modular multiplier: result = (op_x * op_y) mod modulus.
module mrp_modmul #(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] op_x,
  input  logic [W-1:0] op_y,     // must be below modulus
  input  logic [W-1:0] modulus,  // at least 2
  output logic         done,
  output logic [W-1:0] result
);

  localparam int CW = $clog2(W);
  localparam logic [CW-1:0] CNT_LAST = CW'(W - 1);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]  x_r, x_nxt;
  logic [W-1:0]  y_r, y_nxt;
  logic [W-1:0]  n_r, n_nxt;
  logic [W-1:0]  acc_r, acc_nxt;

  logic [W+1:0]  sum;
  logic [W+1:0]  n1;
  logic [W+1:0]  n2;
  logic [W+1:0]  d1;
  logic [W+1:0]  d2;
  logic [W-1:0]  step_res;

  // acc < n and y < n, so 2*acc + y < 3n: at most two subtractions of n
  always_comb begin
    sum = {1'b0, acc_r, 1'b0} + {2'b00, (x_r[W-1] ? y_r : {W{1'b0}})};
    n1  = {2'b00, n_r};
    n2  = {1'b0, n_r, 1'b0};
    d1  = sum - n1;
    d2  = sum - n2;
    if (sum >= n2) begin
      step_res = d2[W-1:0];
    end else if (sum >= n1) begin
      step_res = d1[W-1:0];
    end else begin
      step_res = sum[W-1:0];
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    n_nxt    = n_r;
    acc_nxt  = acc_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      x_nxt    = op_x;
      y_nxt    = op_y;
      n_nxt    = modulus;
      acc_nxt  = '0;
    end else if (busy_r) begin
      acc_nxt = step_res;
      x_nxt   = {x_r[W-2:0], 1'b0};
      cnt_nxt = cnt_r + CW'(1);
      if (cnt_r == CNT_LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    n_r   <= n_nxt;
    acc_r <= acc_nxt;
  end

  assign done   = done_r;
  assign result = acc_r;

endmodule

>>> hw/rtl/miller_rabin_prime_test_core.sv
// Deterministic Miller-Rabin prime test over witness bases 2..41, one shared modular multiplier.
//
// Takes one candidate per request on in_* (low NUM_WIDTH bits used) and returns is_prime on
// out_* (bit 0). in_tready is high only while the sequencer is idle; a finished result sits in
// the output register, so the next candidate can be taken while it waits. Each modular multiply
// runs in the bit-serial multiplier. A witness first reduces its base mod n with one multiply,
// then does NUM_WIDTH squarings plus one multiply per set bit of the odd part m of n-1, then s
// more squarings (n-1 = m*2^s), at most 2*NUM_WIDTH+1 multiplies in all; a base equal to n is
// skipped. A prime goes through all 13 witnesses. A composite usually stops after the first
// witness; 0 and 1 skip the witnesses and go straight to the result.
module miller_rabin_prime_test_core #(
  parameter int NUM_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [mrp_pkg::CAND_W-1:0]     in_tdata,   // [31:0] candidate
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [mrp_pkg::OUT_TDATA_W-1:0] out_tdata  // [0] is_prime, [7:1] zero
);

  localparam int W  = NUM_WIDTH;
  localparam int SW = $clog2(W);
  localparam logic [SW-1:0] EXP_LAST = SW'(W - 1);
  localparam logic [W-1:0]  ONE      = {{(W-1){1'b0}}, 1'b1};

  typedef enum logic [3:0] {
    S_IDLE, S_SPLIT, S_BASE, S_RED, S_ESQ_GO, S_ESQ, S_EMUL_GO, S_EMUL,
    S_EADV, S_CHK0, S_TSQ_CHK, S_TSQ, S_VERDICT, S_NEXT, S_FINISH
  } state_t;

  state_t state_r, state_nxt;

  logic [W-1:0]  n_r, n_nxt;
  logic [W-1:0]  nm1_r, nm1_nxt;
  logic [W-1:0]  m_r, m_nxt;     // odd part of n-1
  logic [SW-1:0] s_r, s_nxt;     // n-1 = m * 2^s
  logic [mrp_pkg::WITNESS_IDX_W-1:0] bidx_r, bidx_nxt;
  logic [W-1:0]  b_r, b_nxt;     // witness reduced mod n
  logic [W-1:0]  acc_r, acc_nxt;
  logic [W-1:0]  e_r, e_nxt;     // exponent, scanned MSB first
  logic [SW-1:0] ecnt_r, ecnt_nxt;
  logic [SW-1:0] sq_r, sq_nxt;
  logic          pass_r, pass_nxt;
  logic          verdict_r, verdict_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [mrp_pkg::OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  logic          mm_start;
  logic [W-1:0]  mm_x;
  logic [W-1:0]  mm_y;
  logic          mm_done;
  logic [W-1:0]  mm_res;
  logic [W-1:0]  base_ext;
  logic [W-1:0]  cand;

  assign base_ext = {{(W-mrp_pkg::BASE_W){1'b0}}, mrp_pkg::witness_base(bidx_r)};
  assign cand     = in_tdata[W-1:0];

  mrp_modmul #(.W(W)) u_modmul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mm_start),
    .op_x    (mm_x),
    .op_y    (mm_y),
    .modulus (n_r),
    .done    (mm_done),
    .result  (mm_res)
  );

  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    nm1_nxt       = nm1_r;
    m_nxt         = m_r;
    s_nxt         = s_r;
    bidx_nxt      = bidx_r;
    b_nxt         = b_r;
    acc_nxt       = acc_r;
    e_nxt         = e_r;
    ecnt_nxt      = ecnt_r;
    sq_nxt        = sq_r;
    pass_nxt      = pass_r;
    verdict_nxt   = verdict_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    out_data_nxt  = out_data_r;
    mm_start      = 1'b0;
    mm_x          = acc_r;
    mm_y          = acc_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          n_nxt   = cand;
          nm1_nxt = cand - ONE;
          m_nxt   = cand - ONE;
          s_nxt   = '0;
          if (cand[W-1:1] == '0) begin
            verdict_nxt = 1'b0;
            state_nxt   = S_FINISH;
          end else begin
            state_nxt = S_SPLIT;
          end
        end
      end
      S_SPLIT: begin
        if (!m_r[0]) begin
          m_nxt = {1'b0, m_r[W-1:1]};
          s_nxt = s_r + SW'(1);
        end else begin
          bidx_nxt  = '0;
          state_nxt = S_BASE;
        end
      end
      S_BASE: begin
        // bases are prime, so a base is a multiple of n > 1 only when equal to n
        if (base_ext == n_r) begin
          state_nxt = S_NEXT;
        end else begin
          mm_start  = 1'b1;
          mm_x      = base_ext;
          mm_y      = ONE;
          state_nxt = S_RED;
        end
      end
      S_RED: begin
        if (mm_done) begin
          b_nxt     = mm_res;
          acc_nxt   = ONE;
          e_nxt     = m_r;
          ecnt_nxt  = '0;
          state_nxt = S_ESQ_GO;
        end
      end
      S_ESQ_GO: begin
        mm_start  = 1'b1;
        state_nxt = S_ESQ;
      end
      S_ESQ: begin
        if (mm_done) begin
          acc_nxt   = mm_res;
          state_nxt = e_r[W-1] ? S_EMUL_GO : S_EADV;
        end
      end
      S_EMUL_GO: begin
        mm_start  = 1'b1;
        mm_y      = b_r;
        state_nxt = S_EMUL;
      end
      S_EMUL: begin
        if (mm_done) begin
          acc_nxt   = mm_res;
          state_nxt = S_EADV;
        end
      end
      S_EADV: begin
        e_nxt    = {e_r[W-2:0], 1'b0};
        ecnt_nxt = ecnt_r + SW'(1);
        if (ecnt_r == EXP_LAST) begin
          state_nxt = S_CHK0;
        end else begin
          state_nxt = S_ESQ_GO;
        end
      end
      S_CHK0: begin
        pass_nxt  = (acc_r == ONE) || (acc_r == nm1_r);
        sq_nxt    = '0;
        state_nxt = S_TSQ_CHK;
      end
      S_TSQ_CHK: begin
        // walk a^(m*2^r) for r = 1..s looking for n-1
        if (sq_r == s_r) begin
          state_nxt = S_VERDICT;
        end else begin
          mm_start  = 1'b1;
          state_nxt = S_TSQ;
        end
      end
      S_TSQ: begin
        if (mm_done) begin
          acc_nxt   = mm_res;
          pass_nxt  = pass_r | (mm_res == nm1_r);
          sq_nxt    = sq_r + SW'(1);
          state_nxt = S_TSQ_CHK;
        end
      end
      S_VERDICT: begin
        if (!pass_r) begin
          verdict_nxt = 1'b0;
          state_nxt   = S_FINISH;
        end else begin
          state_nxt = S_NEXT;
        end
      end
      S_NEXT: begin
        if (bidx_r == mrp_pkg::LAST_WITNESS) begin
          verdict_nxt = 1'b1;
          state_nxt   = S_FINISH;
        end else begin
          bidx_nxt  = bidx_r + mrp_pkg::WITNESS_IDX_W'(1);
          state_nxt = S_BASE;
        end
      end
      S_FINISH: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {{(mrp_pkg::OUT_TDATA_W-1){1'b0}}, verdict_r};
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    n_r        <= n_nxt;
    nm1_r      <= nm1_nxt;
    m_r        <= m_nxt;
    s_r        <= s_nxt;
    bidx_r     <= bidx_nxt;
    b_r        <= b_nxt;
    acc_r      <= acc_nxt;
    e_r        <= e_nxt;
    ecnt_r     <= ecnt_nxt;
    sq_r       <= sq_nxt;
    pass_r     <= pass_nxt;
    verdict_r  <= verdict_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
